[design/xcnc_pkg.sv]
package xcnc_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH     = 4;
  // block position as carried in a queued request; fits blocks up to 16 bytes
  localparam int unsigned KIDX_W          = 4;

  localparam logic [7:0] SEED_INIT   = 8'd23;
  localparam logic [7:0] KEY_BASE    = 8'd11;
  localparam logic [7:0] NIBBLE_BIAS = 8'd180;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       no_data;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic direction;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_ENC,
    OP_DEC_LO,
    OP_DEC_HI
  } op_kind_e;

  // one classified request from the front to the back
  typedef struct packed {
    op_kind_e          kind;
    logic [7:0]        data;
    logic [KIDX_W-1:0] k;
    logic              last;  // message ends with this request: restart the chain
    logic              done;  // decode: this pair completes the block
  } op_t;

  typedef enum logic {
    FR_TAKE,
    FR_PAD
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ENC_HI,
    BK_RD,
    BK_EMIT
  } back_state_e;

  function automatic logic [7:0] key_at(input logic [7:0] k);
    return k + KEY_BASE;
  endfunction

endpackage

[design/xcnc_stream_if.sv]
interface xcnc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/xcnc_queue.sv]
module xcnc_queue #(
  parameter int unsigned Depth = xcnc_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xcnc_pkg::op_t  op_i,
  output logic           full_o,
  input  logic           pop_i,
  output xcnc_pkg::op_t  op_o,
  output logic           empty_o
);
  import xcnc_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  op_t           slot_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign op_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> (!full_o || pop_i))
    else $error("request pushed into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("request popped from an empty queue");
`endif

endmodule

[design/xcnc_front.sv]
module xcnc_front #(
  parameter int unsigned BLOCK_BYTES = xcnc_pkg::BLOCK_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  xcnc_stream_if.sink    in_ch,
  xcnc_stream_if.sink    cfg_ch,
  output logic           restart_o,
  output logic           push_o,
  output xcnc_pkg::op_t  op_o,
  input  logic           full_i
);
  import xcnc_pkg::*;

  localparam int unsigned PW = $clog2(2 * BLOCK_BYTES);
  localparam logic [PW-1:0] ENC_LAST = PW'(BLOCK_BYTES - 1);
  localparam logic [PW-1:0] DEC_LAST = PW'(2 * BLOCK_BYTES - 1);

  front_state_e  state_q, state_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          dir_q;
  logic          take;
  logic          cfg_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign restart_o    = cfg_wr;
  assign take         = in_ch.valid && in_ch.ready;

  // next state and position
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    unique case (state_q)
      FR_TAKE: begin
        if (take) begin
          if (!dir_q) begin
            pos_d = (pos_q == ENC_LAST) ? '0 : pos_q + PW'(1);
            if (in_ch.payload.end_of_message && pos_q != ENC_LAST) begin
              state_d = FR_PAD;
            end
          end else begin
            pos_d = (in_ch.payload.end_of_message || pos_q == DEC_LAST) ? '0
                                                                        : pos_q + PW'(1);
          end
        end
      end
      FR_PAD: begin
        if (!full_i) begin
          pos_d = (pos_q == ENC_LAST) ? '0 : pos_q + PW'(1);
          if (pos_q == ENC_LAST) begin
            state_d = FR_TAKE;
          end
        end
      end
      default: state_d = FR_TAKE;
    endcase
  end

  // classify the request
  always_comb begin
    in_ch.ready = 1'b0;
    push_o      = 1'b0;
    op_o.kind   = OP_ENC;
    op_o.data   = in_ch.payload.data_byte;
    op_o.k      = KIDX_W'(pos_q);
    op_o.last   = 1'b0;
    op_o.done   = 1'b0;
    unique case (state_q)
      FR_TAKE: begin
        in_ch.ready = !full_i;
        push_o      = in_ch.valid && !full_i;
        if (!dir_q) begin
          op_o.last = in_ch.payload.end_of_message && (pos_q == ENC_LAST);
        end else begin
          op_o.kind = pos_q[0] ? OP_DEC_HI : OP_DEC_LO;
          op_o.k    = KIDX_W'(pos_q >> 1);
          op_o.last = in_ch.payload.end_of_message;
          op_o.done = (pos_q == DEC_LAST);
        end
      end
      FR_PAD: begin
        // zero plaintext fills the rest of the block
        push_o    = !full_i;
        op_o.data = '0;
        op_o.last = (pos_q == ENC_LAST);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_TAKE;
      pos_q   <= '0;
      dir_q   <= 1'b0;
    end else if (cfg_wr) begin
      state_q <= FR_TAKE;
      pos_q   <= '0;
      dir_q   <= cfg_ch.payload.direction;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

endmodule

[design/xcnc_back.sv]
module xcnc_back #(
  parameter int unsigned BLOCK_BYTES = xcnc_pkg::BLOCK_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           restart_i,
  input  xcnc_pkg::op_t  op_i,
  input  logic           empty_i,
  output logic           pop_o,
  xcnc_stream_if.source  out_ch
);
  import xcnc_pkg::*;

  localparam int unsigned KW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(BLOCK_BYTES - 1);

  back_state_e   state_q, state_d;
  logic [7:0]    seed_q [BLOCK_BYTES];
  logic [7:0]    plain_mem [BLOCK_BYTES];
  logic [7:0]    rd_q;
  logic [7:0]    e_q;
  logic [7:0]    hold_q;
  logic          last_q;
  logic [KW-1:0] idx_q;
  logic          out_valid_q;
  out_t          out_data_q;

  logic [KW-1:0] hk;
  logic [7:0]    key;
  logic [7:0]    v;
  logic [7:0]    enc_e;
  logic [7:0]    dec_e;
  logic [7:0]    plain_val;
  logic          out_free;

  logic          load;
  out_t          load_data;
  logic          seed_we;
  logic [7:0]    seed_wdata;
  logic          plain_we;
  logic          chain_restart;
  logic          hold_we;
  logic          e_we;
  logic          last_we;
  logic          idx_clr;
  logic          idx_inc;

  assign hk        = KW'(op_i.k);
  assign key       = key_at(8'(op_i.k));
  assign v         = op_i.data - NIBBLE_BIAS;
  assign enc_e     = op_i.data ^ seed_q[hk] ^ key;
  assign dec_e     = hold_q | {v[3:0], 4'b0000};
  assign plain_val = dec_e ^ key ^ seed_q[hk];
  assign out_free  = !out_valid_q || out_ch.ready;

  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_data_q;

  // control outputs
  always_comb begin
    pop_o         = 1'b0;
    load          = 1'b0;
    load_data     = '0;
    seed_we       = 1'b0;
    seed_wdata    = enc_e;
    plain_we      = 1'b0;
    chain_restart = 1'b0;
    hold_we       = 1'b0;
    e_we          = 1'b0;
    last_we       = 1'b0;
    idx_clr       = 1'b0;
    idx_inc       = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          unique case (op_i.kind)
            OP_ENC: begin
              if (out_free) begin
                pop_o                = 1'b1;
                load                 = 1'b1;
                load_data.out_byte   = {4'b0000, enc_e[3:0]} + NIBBLE_BIAS;
                seed_we              = 1'b1;
                chain_restart        = op_i.last;
                e_we                 = 1'b1;
                last_we              = 1'b1;
              end
            end
            OP_DEC_LO: begin
              if (!op_i.last || out_free) begin
                pop_o   = 1'b1;
                hold_we = 1'b1;
                if (op_i.last) begin
                  // partial block at end of message: drop it, flag empty result
                  load                  = 1'b1;
                  load_data.no_data     = 1'b1;
                  load_data.last_of_run = 1'b1;
                  chain_restart         = 1'b1;
                end
              end
            end
            OP_DEC_HI: begin
              if (op_i.done || !op_i.last || out_free) begin
                pop_o         = 1'b1;
                seed_we       = 1'b1;
                seed_wdata    = dec_e;
                plain_we      = 1'b1;
                chain_restart = op_i.last;
                if (op_i.done) begin
                  last_we = 1'b1;
                  idx_clr = 1'b1;
                end else if (op_i.last) begin
                  load                  = 1'b1;
                  load_data.no_data     = 1'b1;
                  load_data.last_of_run = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BK_ENC_HI: begin
        if (out_free) begin
          load                  = 1'b1;
          load_data.out_byte    = {4'b0000, e_q[7:4]} + NIBBLE_BIAS;
          load_data.last_of_run = last_q;
        end
      end
      BK_RD: ;
      BK_EMIT: begin
        if (out_free) begin
          load                  = 1'b1;
          load_data.out_byte    = rd_q;
          load_data.last_of_run = last_q && (idx_q == K_LAST);
          idx_inc               = (idx_q != K_LAST);
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (pop_o && op_i.kind == OP_ENC) begin
          state_d = BK_ENC_HI;
        end else if (pop_o && op_i.kind == OP_DEC_HI && op_i.done) begin
          state_d = BK_RD;
        end
      end
      BK_ENC_HI: if (out_free) state_d = BK_IDLE;
      BK_RD:     state_d = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          state_d = (idx_q == K_LAST) ? BK_IDLE : BK_RD;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load || (out_valid_q && !out_ch.ready);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        seed_q[i] <= SEED_INIT;
      end
    end else if (restart_i || chain_restart) begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        seed_q[i] <= SEED_INIT;
      end
    end else if (seed_we) begin
      seed_q[hk] <= seed_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= load_data;
    end
    if (e_we) begin
      e_q <= enc_e;
    end
    if (hold_we) begin
      hold_q <= v;
    end
    if (last_we) begin
      last_q <= op_i.last;
    end
    if (idx_clr) begin
      idx_q <= '0;
    end else if (idx_inc) begin
      idx_q <= idx_q + KW'(1);
    end
  end

  // decoded block store
  always_ff @(posedge clk_i) begin
    if (plain_we) begin
      plain_mem[hk] <= plain_val;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= plain_mem[idx_q];
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q == BK_ENC_HI) |-> out_valid_q)
    else $error("high nibble pending without a low nibble in the output register");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_data_q.no_data) |-> out_data_q.last_of_run)
    else $error("empty result not marked as last of run");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == BK_RD || state_q == BK_EMIT) |-> !pop_o)
    else $error("request popped during a block burst");
`endif

endmodule

[design/xor_chain_nibble_codec_top.sv]
// Block-chained XOR nibble codec, 8-byte blocks by default.
// Channels: in_ch takes one byte per request (data_byte, end_of_message);
// out_ch gives the results (out_byte, no_data, last_of_run);
// cfg_ch writes the direction bit (0 encode, 1 decode) and restarts the
// chain. Write cfg only while the block is idle.
// Encode: each byte gives two nibble results; a message end pads the block
// with zero bytes, during which in_ch is held off. The low nibble is
// loaded into the output register as the byte leaves the queue, then the
// high nibble; one result per cycle while out_ch is ready, and no new byte
// is popped before the high nibble. Decode: a byte is taken per cycle,
// while the queue is not full, into the 4-entry request queue; a completed
// block drains from the block store one plain byte at a time (store read,
// then output load). A partial block at message end yields one result with
// no_data and last_of_run set. Reset: direction encode, all seeds 23,
// queue and output empty; no clearing pass. A stalled out_ch holds the
// output register; the queue absorbs input until full, then in_ch ready drops.
module xor_chain_nibble_codec_top #(
  parameter int unsigned BLOCK_BYTES = xcnc_pkg::BLOCK_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  xcnc_stream_if.sink   in_ch,
  xcnc_stream_if.sink   cfg_ch,
  xcnc_stream_if.source out_ch
);
  import xcnc_pkg::*;

  op_t  push_op;
  op_t  head_op;
  logic push;
  logic pop;
  logic full;
  logic empty;
  logic restart;

  xcnc_front #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .restart_o (restart),
    .push_o    (push),
    .op_o      (push_op),
    .full_i    (full)
  );

  xcnc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .op_o    (head_op),
    .empty_o (empty)
  );

  xcnc_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .op_i      (head_op),
    .empty_i   (empty),
    .pop_o     (pop),
    .out_ch    (out_ch)
  );

endmodule
